// ===== design/crs_pkg.sv =====
// Shared constants, register codes and neighbour tables for the region statistics block.
package crs_pkg;

  localparam int DEFAULT_MAX_ROWS = 64;
  localparam int DEFAULT_MAX_COLS = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int COUNT_W    = 11;
  localparam int SIZE_W     = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_t;

  // Neighbour offsets, in the order the walk visits them.
  typedef logic signed [1:0] step_t;
  localparam step_t ROW_STEP [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1};
  localparam step_t COL_STEP [8] = '{2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd0, 2'sd1, -2'sd1};

endpackage

// ===== design/crs_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module crs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/connected_region_stats.sv =====
// Counts 8-connected regions of ones in a binary frame and reports the largest region size.
// Pixels are taken one per cycle in raster order into a frame memory whose entries also carry
// a visited flag, which is cleared as each pixel is written. After the last pixel of the frame
// the block walks the frame with an explicit stack held in a second memory: each start position
// is read and checked, each popped pixel is read from the stack, and each in-bounds neighbour
// takes a read and a check, while out-of-bounds neighbours are skipped without a read; closing
// each region updates the count and the largest size. No pixel is taken during the walk. The
// result is held in an output register, so the next frame may load while it waits.
module connected_region_stats #(
  parameter int MAX_ROWS = crs_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = crs_pkg::DEFAULT_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crs_pkg::COUNT_W-1:0]   out_region_count,
  output logic [crs_pkg::SIZE_W-1:0]    out_largest_region,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crs_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW    = RCW + CCW;
  localparam int PW    = AW + CW + 1;

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_START_CHK, S_POP, S_POPW, S_NB, S_NBCHK, S_DONE
  } state_t;

  state_t              state_r;
  logic [CFG_DATA_W-1:0] row_count_r, col_count_r;
  logic [CNTW-1:0]     load_pos_r, start_r, sp_r;
  logic [RCW-1:0]      sr_r, pr_r, nr_r;
  logic [CCW-1:0]      sc_r, pc_r, nc_r;
  logic [AW-1:0]       nidx_r;
  logic [2:0]          k_r;
  logic [SIZE_W-1:0]   cur_r, best_r;
  logic [COUNT_W-1:0]  count_r;
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [SIZE_W-1:0]   out_best_r;

  // Effective frame size: zero reads as one, large values saturate.
  logic [RW-1:0]   rows_eff;
  logic [CW-1:0]   cols_eff;
  logic [CNTW-1:0] frame_size;
  always_comb begin
    if (row_count_r == '0) rows_eff = RW'(1);
    else if (9'(row_count_r) > 9'(MAX_ROWS)) rows_eff = RW'(MAX_ROWS);
    else rows_eff = RW'(row_count_r);
    if (col_count_r == '0) cols_eff = CW'(1);
    else if (9'(col_count_r) > 9'(MAX_COLS)) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(col_count_r);
    frame_size = CNTW'((CNTW+1)'(rows_eff) * (CNTW+1)'(cols_eff));
  end

  // Neighbour k of the popped pixel: bounds check and address.
  logic           nb_ok;
  logic [RCW-1:0] nb_r;
  logic [CCW-1:0] nb_c;
  logic [PW-1:0]  nb_prod;
  always_comb begin
    nb_ok = 1'b1;
    nb_r  = pr_r;
    nb_c  = pc_r;
    if (ROW_STEP[k_r] < 0) begin
      nb_ok = nb_ok && (pr_r != '0);
      nb_r  = pr_r - RCW'(1);
    end else if (ROW_STEP[k_r] > 0) begin
      nb_ok = nb_ok && ((RW+1)'(pr_r) + (RW+1)'(1) < (RW+1)'(rows_eff));
      nb_r  = pr_r + RCW'(1);
    end
    if (COL_STEP[k_r] < 0) begin
      nb_ok = nb_ok && (pc_r != '0);
      nb_c  = pc_r - CCW'(1);
    end else if (COL_STEP[k_r] > 0) begin
      nb_ok = nb_ok && ((CW+1)'(pc_r) + (CW+1)'(1) < (CW+1)'(cols_eff));
      nb_c  = pc_r + CCW'(1);
    end
    nb_prod = PW'(nb_r) * PW'(cols_eff) + PW'(nb_c);
  end

  // Cell memory: bit 1 is the visited flag, bit 0 the pixel.
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [1:0]    cell_wdata, cell_rdata;
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = load_pos_r[AW-1:0];
    cell_wdata = {1'b0, in_pixel};
    cell_raddr = start_r[AW-1:0];
    unique case (state_r)
      S_LOAD: cell_we = in_valid;
      S_START_CHK: begin
        cell_we    = cell_rdata[0] && !cell_rdata[1];
        cell_waddr = start_r[AW-1:0];
        cell_wdata = 2'b11;
      end
      S_NB: cell_raddr = nb_prod[AW-1:0];
      S_NBCHK: begin
        cell_we    = cell_rdata[0] && !cell_rdata[1];
        cell_waddr = nidx_r;
        cell_wdata = 2'b11;
      end
      default: ;
    endcase
  end

  crs_ram #(.WIDTH(2), .DEPTH(CELLS), .AW(AW)) u_cells (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  // Walk stack holds row and column of pixels awaiting a visit.
  logic          stk_we;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic [CNTW-1:0] sp_dec;
  assign sp_dec = sp_r - CNTW'(1);
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = {sr_r, sc_r};
    if (state_r == S_START_CHK) begin
      stk_we = cell_rdata[0] && !cell_rdata[1];
    end else if (state_r == S_NBCHK) begin
      stk_we    = cell_rdata[0] && !cell_rdata[1];
      stk_wdata = {nr_r, nc_r};
    end
  end

  crs_ram #(.WIDTH(SW), .DEPTH(CELLS), .AW(AW)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp_r[AW-1:0]), .wdata(stk_wdata),
    .raddr(sp_dec[AW-1:0]), .rdata(stk_rdata)
  );

  assign in_ready           = (state_r == S_LOAD);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_region_count   = out_count_r;
  assign out_largest_region = out_best_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_DATA_W'(64);
      col_count_r <= CFG_DATA_W'(64);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_COUNT) row_count_r <= cfg_data;
      else if (cfg_index == REG_COL_COUNT) col_count_r <= cfg_data;
    end
  end

  // Load and walk sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_pos_r  <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (load_pos_r + CNTW'(1) >= frame_size) begin
              load_pos_r <= '0;
              start_r    <= '0;
              sr_r       <= '0;
              sc_r       <= '0;
              count_r    <= '0;
              best_r     <= '0;
              sp_r       <= '0;
              state_r    <= S_START;
            end else begin
              load_pos_r <= load_pos_r + CNTW'(1);
            end
          end
        end
        S_START: begin
          state_r <= (start_r < frame_size) ? S_START_CHK : S_DONE;
        end
        S_START_CHK: begin
          if (cell_rdata[0] && !cell_rdata[1]) begin
            sp_r    <= CNTW'(1);
            cur_r   <= '0;
            state_r <= S_POP;
          end else begin
            state_r <= S_START;
          end
          if (!(cell_rdata[0] && !cell_rdata[1])) begin
            start_r <= start_r + CNTW'(1);
            if (CW'(sc_r) + CW'(1) == cols_eff) begin
              sc_r <= '0;
              sr_r <= sr_r + RCW'(1);
            end else begin
              sc_r <= sc_r + CCW'(1);
            end
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            if (count_r != COUNT_MAX) count_r <= count_r + COUNT_W'(1);
            if (cur_r > best_r) best_r <= cur_r;
            start_r <= start_r + CNTW'(1);
            if (CW'(sc_r) + CW'(1) == cols_eff) begin
              sc_r <= '0;
              sr_r <= sr_r + RCW'(1);
            end else begin
              sc_r <= sc_r + CCW'(1);
            end
            state_r <= S_START;
          end else begin
            sp_r    <= sp_dec;
            state_r <= S_POPW;
          end
        end
        S_POPW: begin
          {pr_r, pc_r} <= stk_rdata;
          if (cur_r != SIZE_MAX) cur_r <= cur_r + SIZE_W'(1);
          k_r     <= '0;
          state_r <= S_NB;
        end
        S_NB: begin
          nr_r   <= nb_r;
          nc_r   <= nb_c;
          nidx_r <= nb_prod[AW-1:0];
          if (nb_ok) begin
            state_r <= S_NBCHK;
          end else begin
            k_r <= k_r + 3'd1;
            if (k_r == 3'd7) state_r <= S_POP;
          end
        end
        S_NBCHK: begin
          if (cell_rdata[0] && !cell_rdata[1]) sp_r <= sp_r + CNTW'(1);
          k_r     <= k_r + 3'd1;
          state_r <= (k_r == 3'd7) ? S_POP : S_NB;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_r;
            out_best_r  <= best_r;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
